// ===== src/hbsd_pkg.sv =====
// Shared types, codes and helpers of the bit-serial table-match decoder.
`timescale 1ns / 1ps

package hbsd_pkg;

   localparam int DEF_TABLE_DEPTH  = 256;
   localparam int DEF_MAX_CODE_LEN = 32;

   localparam int SYMBOL_W  = 8;
   localparam int CODE_W    = 32;
   localparam int LENGTH_W  = 6;
   localparam int REQ_DATA_W = 48;

   typedef logic [1:0] cmd_type;

   localparam cmd_type CMD_CLEAR = 2'd0;
   localparam cmd_type CMD_LOAD  = 2'd1;
   localparam cmd_type CMD_BIT   = 2'd2;

   typedef struct packed {
      logic                code_bit;
      logic [LENGTH_W-1:0] length;
      logic [CODE_W-1:0]   code;
      logic [SYMBOL_W-1:0] symbol;
   } req_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic [CODE_W-1:0]   code;
      logic [LENGTH_W-1:0] length;
   } entry_type;

   typedef struct packed {
      logic                overflow;
      logic [SYMBOL_W-1:0] symbol;
   } result_type;

   // Keep only the low len bits of a code word.
   function automatic logic [CODE_W-1:0] code_mask(input logic [LENGTH_W-1:0] len);
      logic [CODE_W-1:0] mask;
      if (len >= LENGTH_W'(CODE_W)) begin
         mask = '1;
      end else begin
         mask = (CODE_W'(1) << len[4:0]) - CODE_W'(1);
      end
      return mask;
   endfunction

endpackage

// ===== src/hbsd_table_ram.sv =====
// Code table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module hbsd_table_ram #(
   parameter int DEPTH = hbsd_pkg::DEF_TABLE_DEPTH,
   parameter int AW    = $clog2(hbsd_pkg::DEF_TABLE_DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  hbsd_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output hbsd_pkg::entry_type rd_data
);
   import hbsd_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/hbsd_scan_ctrl.sv =====
// Command decode, bit accumulator and sequential table scan.
`timescale 1ns / 1ps

module hbsd_scan_ctrl #(
   parameter int TABLE_DEPTH  = hbsd_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_CODE_LEN = hbsd_pkg::DEF_MAX_CODE_LEN,
   parameter int AW           = $clog2(hbsd_pkg::DEF_TABLE_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hbsd_pkg::cmd_type    req_command,
   input  hbsd_pkg::req_type    req_item,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output hbsd_pkg::entry_type  wr_data,
   output logic                 rd_en,
   output logic [AW-1:0]        rd_addr,
   input  hbsd_pkg::entry_type  rd_data,
   output logic                 res_valid,
   input  logic                 res_ready,
   output hbsd_pkg::result_type res_data
);
   import hbsd_pkg::*;

   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int ALW = $clog2(MAX_CODE_LEN + 1);
   localparam int LW  = (ALW > LENGTH_W) ? ALW : LENGTH_W;
   localparam int XW  = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [MAX_CODE_LEN-1:0] acc_ff, acc_in;
   logic [ALW-1:0]          acc_len_ff, acc_len_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           rd_addr_ff, rd_addr_in;
   logic                    cmp_valid_ff, cmp_valid_in;
   result_type              res_ff, res_in;

   logic issue;
   logic hit;

   assign issue = rd_addr_ff < count_ff;
   assign hit   = cmp_valid_ff
                  && (LW'(rd_data.length) == LW'(acc_len_ff))
                  && (XW'(rd_data.code) == XW'(acc_ff));

   assign wr_addr        = count_ff[AW-1:0];
   assign wr_data.symbol = req_item.symbol;
   assign wr_data.code   = req_item.code & code_mask(req_item.length);
   assign wr_data.length = req_item.length;
   assign rd_addr        = rd_addr_ff[AW-1:0];

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_EMIT);
   assign res_data  = res_ff;

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      acc_len_in   = acc_len_ff;
      count_in     = count_ff;
      rd_addr_in   = rd_addr_ff;
      cmp_valid_in = 1'b0;
      res_in       = res_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_command)
                  CMD_CLEAR: begin
                     count_in   = '0;
                     acc_in     = '0;
                     acc_len_in = '0;
                  end
                  CMD_LOAD: begin
                     if (count_ff < CW'(TABLE_DEPTH)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_BIT: begin
                     acc_in     = {acc_ff[MAX_CODE_LEN-2:0], req_item.code_bit};
                     acc_len_in = acc_len_ff + ALW'(1);
                     rd_addr_in = '0;
                     state_in   = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               res_in.symbol   = rd_data.symbol;
               res_in.overflow = 1'b0;
               acc_in          = '0;
               acc_len_in      = '0;
               state_in        = ST_EMIT;
            end else if (issue) begin
               rd_en        = 1'b1;
               rd_addr_in   = rd_addr_ff + CW'(1);
               cmp_valid_in = 1'b1;
            end else if (acc_len_ff >= ALW'(MAX_CODE_LEN)) begin
               res_in.symbol   = '0;
               res_in.overflow = 1'b1;
               acc_in          = '0;
               acc_len_in      = '0;
               state_in        = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         acc_len_ff   <= '0;
         count_ff     <= '0;
         rd_addr_ff   <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         acc_len_ff   <= acc_len_in;
         count_ff     <= count_in;
         rd_addr_ff   <= rd_addr_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      acc_len_ff <= ALW'(MAX_CODE_LEN))
      else $error("accumulated length beyond maximum code length");

   a_cmp_from_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> ($past(state_ff) == ST_SCAN) && (state_ff == ST_SCAN))
      else $error("compare slot valid outside a scan");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !res_ready) |=> (state_ff == ST_EMIT) && $stable(res_ff))
      else $error("pending result dropped while output stalled");

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && res_ff.overflow) |-> (res_ff.symbol == '0))
      else $error("overflow result carries a symbol");

endmodule

// ===== src/hbsd_out_reg.sv =====
// Result output register that decouples the scan from the result consumer.
`timescale 1ns / 1ps

module hbsd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hbsd_pkg::result_type in_result,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output hbsd_pkg::result_type rsp_result
);
   import hbsd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign in_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = data_ff;

endmodule

// ===== src/huffman_bit_serial_decoder_core.sv =====
// Top level of the bit-serial table-match prefix code decoder.
`timescale 1ns / 1ps

// Channel  | Direction | Transaction content
// ---------+-----------+--------------------------------------------------
// req_     | in        | clear / load entry / code bit (kind in tuser)
// rsp_     | out       | decoded symbol, overflow flag in tuser
//
// Clear and load transactions complete in idle. A code bit transaction
// scans the loaded entries one per cycle through the single table read port
// and takes no further request until the scan ends: a match ends it with
// the matching symbol; without a match it returns to idle, or gives an
// overflow result at the maximum code length. Synchronous reset clears the
// entry count, the accumulator and the handshake state; table contents are
// kept and never read before being loaded. A stalled rsp_ channel holds the
// result in the output register while the next request is taken; a second
// result then waits in the scan controller until the register frees up.

module huffman_bit_serial_decoder_core #(
   parameter int TABLE_DEPTH  = hbsd_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_CODE_LEN = hbsd_pkg::DEF_MAX_CODE_LEN
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] entry_symbol, [39:8] entry_code, [45:40] entry_length,
   // [46] code_bit, [47] zero
   input  logic [hbsd_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] decoded_symbol
   output logic [7:0]                      rsp_tdata,
   // [0] overflow
   output logic [0:0]                      rsp_tuser
);
   import hbsd_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   req_type    req_item;
   entry_type  wr_data;
   entry_type  rd_data;
   logic       wr_en;
   logic       rd_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic       res_valid;
   logic       res_ready;
   result_type res_data;
   result_type rsp_result;

   // Unpack the request transaction fields.
   assign req_item.symbol   = req_tdata[7:0];
   assign req_item.code     = req_tdata[39:8];
   assign req_item.length   = req_tdata[45:40];
   assign req_item.code_bit = req_tdata[46];

   hbsd_scan_ctrl #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .AW           (AW)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_command (req_tuser),
      .req_item    (req_item),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_data    (res_data)
   );

   // Table storage: written on load, read once per scan step.
   hbsd_table_ram #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Hold results for the consumer so the scan can take the next request.
   hbsd_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (res_valid),
      .in_ready   (res_ready),
      .in_result  (res_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata    = rsp_result.symbol;
   assign rsp_tuser[0] = rsp_result.overflow;

endmodule
